@@ src/tsgd_pkg.sv @@
`default_nettype none

package tsgd_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned LEVEL_W    = 4;
    localparam int unsigned PAD_IDX_W  = 2;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned POLL_W     = 10;
    localparam int unsigned SLIDE_W    = 16;
    localparam int unsigned CLICK_W    = 15;
    localparam int unsigned CLEAR_W    = 16;

    localparam logic [POLL_W-1:0]  POLL_PERIOD_RST = 10'd50;
    localparam logic [SLIDE_W-1:0] SLIDE_LIMIT_RST = 16'd400;
    localparam logic [CLICK_W-1:0] CLICK_LIMIT_RST = 15'd250;
    localparam logic [CLEAR_W-1:0] CLEAR_DELAY_RST = 16'd100;

    localparam logic [PAD_IDX_W-1:0] FIRST_PAD_RST = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLL_PERIOD = 8'd0,
        CFG_SLIDE_LIMIT = 8'd1,
        CFG_CLICK_LIMIT = 8'd2,
        CFG_CLEAR_DELAY = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [POLL_W-1:0]  poll_period;
        logic [SLIDE_W-1:0] slide_limit;
        logic [CLICK_W-1:0] click_limit;
        logic [CLEAR_W-1:0] clear_delay;
    } cfg_t;

    typedef struct packed {
        logic pressed;
        logic released;
        logic left_slide;
        logic right_slide;
        logic click;
        logic dbl_click;
    } events_t;

endpackage

`default_nettype wire

@@ src/tsgd_if.sv @@
`default_nettype none

interface tsgd_sense_if;
    import tsgd_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] sensor_levels;
    modport source (output valid, output sensor_levels, input ready);
    modport sink   (input valid, input sensor_levels, output ready);
endinterface

interface tsgd_event_if;
    logic valid;
    logic ready;
    logic ev_pressed;
    logic ev_released;
    logic ev_slide_left;
    logic ev_slide_right;
    logic ev_click;
    logic ev_double_click;
    modport source (output valid, output ev_pressed, output ev_released,
                    output ev_slide_left, output ev_slide_right, output ev_click,
                    output ev_double_click, input ready);
    modport sink   (input valid, input ev_pressed, input ev_released,
                    input ev_slide_left, input ev_slide_right, input ev_click,
                    input ev_double_click, output ready);
endinterface

interface tsgd_cfg_if;
    import tsgd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/touch_strip_gesture_detector.sv @@
// Touch strip gesture detector.
// sensor: one word per poll tick, the four pad levels (bit i = pad i touched).
// events: one word per tick with six event flags; all flags are zero on a
//   quiet tick, but the word is still delivered.
// cfg: register writes (index 0 poll period, 1 slide limit, 2 click limit,
//   3 clear delay); always ready, unknown indexes are dropped. Write only
//   while no tick is in flight.
// Path: a tick taken into the input register moves on to the event
//   register when that register is free or its word is being taken, and
//   its event word is then offered on the events channel.
// Throughput: one tick per clock while events.ready is high; the gesture
//   state updates as each tick moves on, so ticks then follow with no gap.
// Stall: while the event word waits, one more tick is taken into the input
//   register; after that sensor.ready drops until the word is taken.
// Reset: clock and timestamps clear, sensing is armed, registers return to
//   50 / 400 / 250 / 100 ms, and both channels come up empty.
`default_nettype none

module touch_strip_gesture_detector (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tsgd_sense_if.sink   sensor,
    tsgd_event_if.source events,
    tsgd_cfg_if.sink     cfg
);
    import tsgd_pkg::*;

    cfg_t               cfg_val;
    logic               in_valid;
    logic [LEVEL_W-1:0] in_levels;
    logic               out_free;
    logic               advance;
    events_t            step_ev;

    // advance the held tick when the event register can take its word
    assign advance = in_valid && out_free;

    tsgd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    tsgd_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .sensor  (sensor),
        .advance (advance),
        .valid   (in_valid),
        .levels  (in_levels)
    );

    tsgd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_val),
        .step   (advance),
        .levels (in_levels),
        .ev     (step_ev)
    );

    tsgd_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .ev_in  (step_ev),
        .free   (out_free),
        .events (events)
    );

endmodule

`default_nettype wire

@@ src/tsgd_cfg_regs.sv @@
`default_nettype none

module tsgd_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tsgd_cfg_if.sink     cfg,
    output tsgd_pkg::cfg_t cfg_val
);
    import tsgd_pkg::*;

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_period <= POLL_PERIOD_RST;
            cfg_reg.slide_limit <= SLIDE_LIMIT_RST;
            cfg_reg.click_limit <= CLICK_LIMIT_RST;
            cfg_reg.clear_delay <= CLEAR_DELAY_RST;
        end
        else if (cfg.valid)
        begin
            // keep the low bits of the word; drop writes to unknown indexes
            case (cfg_idx_t'(cfg.index))
                CFG_POLL_PERIOD: cfg_reg.poll_period <= cfg.data[POLL_W-1:0];
                CFG_SLIDE_LIMIT: cfg_reg.slide_limit <= cfg.data[SLIDE_W-1:0];
                CFG_CLICK_LIMIT: cfg_reg.click_limit <= cfg.data[CLICK_W-1:0];
                CFG_CLEAR_DELAY: cfg_reg.clear_delay <= cfg.data[CLEAR_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/tsgd_in_stage.sv @@
`default_nettype none

module tsgd_in_stage (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tsgd_sense_if.sink sensor,
    input  wire logic  advance,
    output logic       valid,
    output logic [tsgd_pkg::LEVEL_W-1:0] levels
);
    import tsgd_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [LEVEL_W-1:0] levels_reg;
    logic               accept;

    assign sensor.ready = !valid_reg || advance;
    assign accept       = sensor.valid && sensor.ready;
    assign valid        = valid_reg;
    assign levels       = levels_reg;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            levels_reg <= sensor.sensor_levels;
    end

endmodule

`default_nettype wire

@@ src/tsgd_core.sv @@
`default_nettype none

module tsgd_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire tsgd_pkg::cfg_t             cfg,
    input  wire logic                       step,
    input  wire logic [tsgd_pkg::LEVEL_W-1:0] levels,
    output tsgd_pkg::events_t               ev
);
    import tsgd_pkg::*;

    logic [TIME_W-1:0]    time_reg,        time_next;
    logic                 press_reg,       press_next;
    logic                 pending_reg,     pending_next;
    logic                 armed_reg,       armed_next;
    logic                 clean_reg,       clean_next;
    logic [PAD_IDX_W-1:0] first_pad_reg,   first_pad_next;
    logic                 left_reg,        left_next;
    logic [LEVEL_W-1:0]   pads_reg,        pads_next;
    logic [TIME_W-1:0]    press_start_reg, press_start_next;
    logic [TIME_W-1:0]    last_click_reg,  last_click_next;
    logic [TIME_W-1:0]    release_reg,     release_next;

    logic                 touching;
    logic                 new_press;
    logic                 release_now;
    logic [PAD_IDX_W-1:0] low_pad;
    logic [TIME_W-1:0]    held;
    logic [TIME_W-1:0]    since_click;
    logic [TIME_W-1:0]    since_release;
    logic [PAD_IDX_W-1:0] tgt_idx;
    logic                 target_hit;
    logic                 is_slide;
    logic                 is_click;
    logic                 dbl_window;
    logic                 fire_click;
    logic                 do_clear;

    always_comb
    begin
        if (levels[0])
            low_pad = 2'd0;
        else if (levels[1])
            low_pad = 2'd1;
        else if (levels[2])
            low_pad = 2'd2;
        else
            low_pad = 2'd3;
    end

    always_comb
    begin
        time_next   = time_reg + TIME_W'(cfg.poll_period);
        touching    = armed_reg && (levels != '0);
        new_press   = touching && !press_reg;
        release_now = press_reg && !touching;

        held          = time_next - press_start_reg;
        since_click   = time_next - last_click_reg;
        since_release = time_next - release_reg;

        // two steps along the slide; a start at the strip end also checks three
        tgt_idx    = left_reg ? (first_pad_reg - 2'd2) : (first_pad_reg + 2'd2);
        target_hit = pads_reg[tgt_idx]
                     || (left_reg && (first_pad_reg == 2'd3) && pads_reg[0])
                     || (!left_reg && (first_pad_reg == 2'd0) && pads_reg[3]);

        is_slide   = release_now && target_hit
                     && (held <= TIME_W'(cfg.slide_limit));
        is_click   = release_now && !is_slide
                     && (held <= TIME_W'(cfg.click_limit));
        dbl_window = since_click < TIME_W'({cfg.click_limit, 1'b0});

        // a click recorded this tick has zero age and cannot time out
        fire_click = pending_reg && !is_click
                     && (since_click > TIME_W'(cfg.click_limit));

        if (is_click)
            pending_next = !dbl_window;
        else if (fire_click)
            pending_next = 1'b0;
        else
            pending_next = pending_reg;

        if (new_press)
            press_next = 1'b1;
        else if (release_now)
            press_next = 1'b0;
        else
            press_next = press_reg;

        armed_next = release_now ? 1'b0 : armed_reg;
        clean_next = new_press ? 1'b0 : clean_reg;
        pads_next  = touching ? (pads_reg | levels) : pads_reg;

        // a release this tick has zero age, so only older releases re-arm
        do_clear = !press_next && !release_now && (!clean_next || !armed_next)
                   && (since_release > TIME_W'(cfg.clear_delay));
        if (do_clear)
        begin
            armed_next = 1'b1;
            clean_next = 1'b1;
            pads_next  = '0;
        end

        first_pad_next   = new_press ? low_pad : first_pad_reg;
        left_next        = new_press ? low_pad[1] : left_reg;
        press_start_next = new_press ? time_next : press_start_reg;
        last_click_next  = is_click ? time_next : last_click_reg;
        release_next     = release_now ? time_next : release_reg;

        ev.pressed     = new_press;
        ev.released    = release_now;
        ev.left_slide  = is_slide && left_reg;
        ev.right_slide = is_slide && !left_reg;
        ev.click       = fire_click;
        ev.dbl_click   = is_click && dbl_window;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg        <= '0;
            press_reg       <= 1'b0;
            pending_reg     <= 1'b0;
            armed_reg       <= 1'b1;
            clean_reg       <= 1'b1;
            first_pad_reg   <= FIRST_PAD_RST;
            left_reg        <= 1'b0;
            pads_reg        <= '0;
            press_start_reg <= '0;
            last_click_reg  <= '0;
            release_reg     <= '0;
        end
        else if (step)
        begin
            time_reg        <= time_next;
            press_reg       <= press_next;
            pending_reg     <= pending_next;
            armed_reg       <= armed_next;
            clean_reg       <= clean_next;
            first_pad_reg   <= first_pad_next;
            left_reg        <= left_next;
            pads_reg        <= pads_next;
            press_start_reg <= press_start_next;
            last_click_reg  <= last_click_next;
            release_reg     <= release_next;
        end
    end

endmodule

`default_nettype wire

@@ src/tsgd_out_stage.sv @@
`default_nettype none

module tsgd_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire tsgd_pkg::events_t ev_in,
    output logic                   free,
    tsgd_event_if.source           events
);
    import tsgd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    events_t ev_reg;

    assign free   = !valid_reg || events.ready;
    assign events.valid           = valid_reg;
    assign events.ev_pressed      = ev_reg.pressed;
    assign events.ev_released     = ev_reg.released;
    assign events.ev_slide_left   = ev_reg.left_slide;
    assign events.ev_slide_right  = ev_reg.right_slide;
    assign events.ev_click        = ev_reg.click;
    assign events.ev_double_click = ev_reg.dbl_click;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (events.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            ev_reg <= ev_in;
    end

endmodule

`default_nettype wire

@@ src/tsgd_checker.sv @@
`default_nettype none

module tsgd_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic ev_pressed,
    input wire logic ev_released,
    input wire logic ev_slide_left,
    input wire logic ev_slide_right,
    input wire logic ev_click,
    input wire logic ev_double_click
);

    // a touch cannot begin and end on the same tick
    a_press_release_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(ev_pressed && ev_released))
        else $error("pressed and released in one word");

    // a slide or a double click is always reported with its release
    a_gesture_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (ev_slide_left || ev_slide_right || ev_double_click))
            |-> ev_released)
        else $error("gesture without release");

    // at most one of slide left, slide right, double click per word; a pending
    // click may still time out on the same tick
    a_gesture_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({ev_slide_left, ev_slide_right, ev_double_click}))
        else $error("conflicting gesture flags");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid
            && $stable({ev_pressed, ev_released, ev_slide_left, ev_slide_right,
                        ev_click, ev_double_click})))
        else $error("event word changed while stalled");

endmodule

bind touch_strip_gesture_detector tsgd_checker u_tsgd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (events.valid),
    .out_ready       (events.ready),
    .ev_pressed      (events.ev_pressed),
    .ev_released     (events.ev_released),
    .ev_slide_left   (events.ev_slide_left),
    .ev_slide_right  (events.ev_slide_right),
    .ev_click        (events.ev_click),
    .ev_double_click (events.ev_double_click)
);

`default_nettype wire

@@ sim/touch_strip_gesture_detector_tb.sv @@
`timescale 1ns / 1ps

module touch_strip_gesture_detector_tb;
    import tsgd_pkg::*;

    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASES       = 6;
    localparam int SPAN_CAP     = 80;

    // Indexes past the last register; the block must drop these writes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_IDX_W'(CFG_CLEAR_DELAY) + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = '1;

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    tsgd_sense_if sensor_bus ();
    tsgd_event_if event_bus ();
    tsgd_cfg_if   cfg_bus ();

    touch_strip_gesture_detector u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sensor (sensor_bus),
        .events (event_bus),
        .cfg    (cfg_bus)
    );

    // ------------------------------------------------------------------
    // Gesture predictor: own copy of the registers and the gesture state.
    // ------------------------------------------------------------------
    bit [POLL_W-1:0]    poll_ms;
    bit [SLIDE_W-1:0]   slide_ms;
    bit [CLICK_W-1:0]   click_ms;
    bit [CLEAR_W-1:0]   clear_ms;

    bit [TIME_W-1:0]    t_now;
    bit [TIME_W-1:0]    t_press;
    bit [TIME_W-1:0]    t_click;
    bit [TIME_W-1:0]    t_release;
    bit                 pressing;
    bit                 pend_click;
    bit                 is_armed;
    bit                 clean;
    bit [PAD_IDX_W-1:0] lead_pad;
    bit                 go_left;
    bit [LEVEL_W-1:0]   pads_hit;

    task automatic reset_gesture_model();
        poll_ms    = POLL_PERIOD_RST;
        slide_ms   = SLIDE_LIMIT_RST;
        click_ms   = CLICK_LIMIT_RST;
        clear_ms   = CLEAR_DELAY_RST;
        t_now      = '0;
        t_press    = '0;
        t_click    = '0;
        t_release  = '0;
        pressing   = 1'b0;
        pend_click = 1'b0;
        is_armed   = 1'b1;
        clean      = 1'b1;
        lead_pad   = FIRST_PAD_RST;
        go_left    = 1'b0;
        pads_hit   = '0;
    endtask

    // Register write as the block sees it: truncate to the field width,
    // drop anything with an index past the list.
    task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_POLL_PERIOD: poll_ms  = val[POLL_W-1:0];
            CFG_SLIDE_LIMIT: slide_ms = val[SLIDE_W-1:0];
            CFG_CLICK_LIMIT: click_ms = val[CLICK_W-1:0];
            CFG_CLEAR_DELAY: clear_ms = val[CLEAR_W-1:0];
            default: ;
        endcase
    endtask

    // One poll tick: advance the clock, then press, release, click timeout
    // and re-arm, in that order.
    function automatic events_t predict_tick(input logic [LEVEL_W-1:0] levels);
        events_t            ev;
        bit                 touching;
        bit                 hit;
        int                 p;
        bit [PAD_IDX_W-1:0] target;
        bit [TIME_W-1:0]    held;
        bit [TIME_W-1:0]    since_click;
        ev       = '0;
        touching = 1'b0;
        hit      = 1'b0;
        t_now    = t_now + poll_ms;

        // Levels only count while armed.
        if (is_armed && levels != '0)
        begin
            if (!pressing)
            begin
                p = 0;
                while (!levels[p])
                    p++;
                clean      = 1'b0;
                pressing   = 1'b1;
                lead_pad   = p[PAD_IDX_W-1:0];
                go_left    = (p >= 2);
                t_press    = t_now;
                ev.pressed = 1'b1;
            end
            pads_hit = pads_hit | levels;
            touching = 1'b1;
        end

        if (pressing && !touching)
        begin
            held      = t_now - t_press;
            is_armed  = 1'b0;
            pressing  = 1'b0;
            t_release = t_now;
            // Target two pads along; from an end pad also three along.
            if (go_left)
            begin
                target = lead_pad - 2'd2;
                hit    = pads_hit[target] || (lead_pad == 2'd3 && pads_hit[0]);
            end
            else
            begin
                target = lead_pad + 2'd2;
                hit    = pads_hit[target] || (lead_pad == 2'd0 && pads_hit[3]);
            end
            if (held <= slide_ms && hit)
            begin
                if (go_left)
                    ev.left_slide = 1'b1;
                else
                    ev.right_slide = 1'b1;
            end
            else if (held <= click_ms)
            begin
                since_click = t_now - t_click;
                if (since_click < {click_ms, 1'b0})
                begin
                    pend_click   = 1'b0;
                    ev.dbl_click = 1'b1;
                end
                else
                begin
                    pend_click = 1'b1;
                end
                t_click = t_now;
            end
            ev.released = 1'b1;
        end

        since_click = t_now - t_click;
        if (pend_click && since_click > click_ms)
        begin
            pend_click = 1'b0;
            ev.click   = 1'b1;
        end

        if (!pressing && (!clean || !is_armed) && (t_now - t_release) > clear_ms)
        begin
            is_armed = 1'b1;
            clean    = 1'b1;
            pads_hit = '0;
        end
        return ev;
    endfunction

    function automatic string flag_text(input events_t e);
        return $sformatf("press=%0b rel=%0b sl=%0b sr=%0b click=%0b dbl=%0b",
                         e.pressed, e.released, e.left_slide, e.right_slide,
                         e.click, e.dbl_click);
    endfunction

    // ------------------------------------------------------------------
    // Queues, counters and idling knobs.
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0] pending_levels [$];
    events_t            expected_events [$];

    bit  sense_taken;
    bit  calm;
    int  gap_pct;
    int  stall_pct;
    int  src_gap;
    int  sink_gap;
    int  cycles;
    int  ticks_queued;
    int  ticks_sent;
    int  words_checked;
    int  failures;
    int  settings_used;
    int  seen_press;
    int  seen_slide;
    int  seen_click;
    int  seen_double;

    // Directed ticks at reset settings (poll 50 ms): early double click right
    // after reset, a full press ignored while not armed, a rightward slide
    // from pad 1 to pad 3, a leftward slide from pad 3,
    // a single tap that times out into a click, and all pads at once.
    logic [LEVEL_W-1:0] directed_ticks [$] = '{
        4'b0001, 4'b0000,
        4'b1111, 4'b0000, 4'b0000,
        4'b0010, 4'b0110, 4'b1100, 4'b1000, 4'b0000,
        4'b0000, 4'b0000, 4'b0000,
        4'b1000, 4'b0100, 4'b0010, 4'b0000,
        4'b0000, 4'b0000, 4'b0000,
        4'b0100, 4'b0000,
        4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b0000,
        4'b1111, 4'b0000
    };

    // ------------------------------------------------------------------
    // Sensor driver: change at the falling edge, hold a word until taken.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sensor_bus.valid <= 1'b0;
        end
        else if (!sensor_bus.valid || sense_taken)
        begin
            if (src_gap > 0)
            begin
                src_gap = src_gap - 1;
                sensor_bus.valid <= 1'b0;
            end
            else if (pending_levels.size() != 0 && !calm &&
                     $urandom_range(0, 99) < gap_pct)
            begin
                // start a burst of idle cycles, this one included
                src_gap = $urandom_range(0, 12);
                sensor_bus.valid <= 1'b0;
            end
            else if (pending_levels.size() != 0)
            begin
                sensor_bus.valid         <= 1'b1;
                sensor_bus.sensor_levels <= pending_levels.pop_front();
            end
            else
            begin
                sensor_bus.valid <= 1'b0;
            end
        end
    end

    // Event sink: stall in bursts, never in the calm tail of the run.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            event_bus.ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap = sink_gap - 1;
            event_bus.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < stall_pct)
        begin
            sink_gap = $urandom_range(0, 12);
            event_bus.ready <= 1'b0;
        end
        else
        begin
            event_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted tick, check every accepted word.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        events_t got;
        events_t want;
        sense_taken <= sensor_bus.valid && sensor_bus.ready;

        if (rst_n && sensor_bus.valid && sensor_bus.ready)
        begin
            expected_events.push_back(predict_tick(sensor_bus.sensor_levels));
            ticks_sent++;
        end

        if (rst_n && event_bus.valid && event_bus.ready)
        begin
            got = {event_bus.ev_pressed, event_bus.ev_released,
                   event_bus.ev_slide_left, event_bus.ev_slide_right,
                   event_bus.ev_click, event_bus.ev_double_click};
            seen_press  += got.pressed;
            seen_slide  += got.left_slide + got.right_slide;
            seen_click  += got.click;
            seen_double += got.dbl_click;
            if (expected_events.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] event word with no tick pending: %s", $realtime,
                             flag_text(got));
            end
            else
            begin
                want = expected_events.pop_front();
                words_checked++;
                if (got.pressed !== want.pressed || got.released !== want.released ||
                    got.left_slide !== want.left_slide ||
                    got.right_slide !== want.right_slide ||
                    got.click !== want.click || got.dbl_click !== want.dbl_click)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("[%0t] event word %0d: expected %s, got %s", $realtime,
                                 words_checked, flag_text(want), flag_text(got));
                end
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected", cycles,
                     expected_events.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_tick(input logic [LEVEL_W-1:0] lv);
        pending_levels.push_back(lv);
        ticks_queued++;
    endtask

    // Duration in ticks at the current poll period, capped to keep gestures short.
    function automatic int span(input int ms);
        int per;
        int n;
        per = (poll_ms == '0) ? 1 : int'(poll_ms);
        n   = ms / per;
        return (n > SPAN_CAP) ? SPAN_CAP : n;
    endfunction

    task automatic queue_tap(input int max_hold);
        int               hold;
        logic [LEVEL_W-1:0] lv;
        hold = $urandom_range(1, max_hold);
        lv   = ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom_range(1, 15))
                                           : LEVEL_W'(1 << $urandom_range(0, 3));
        repeat (hold)
            queue_tick(lv);
        queue_tick('0);
    endtask

    // Quiet lead-in (sometimes too short to re-arm), then one gesture.
    task automatic queue_gesture();
        int                 kind;
        int                 pad;
        int                 steps;
        int                 hold;
        int                 cur;
        int                 k;
        bit                 left;
        logic [LEVEL_W-1:0] lv;
        repeat ($urandom_range(0, span(clear_ms) + 2))
            queue_tick('0);
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            // slide: walk pad by pad, sometimes overlapping the next pad
            left  = 1'($urandom_range(0, 1));
            pad   = left ? $urandom_range(2, 3) : $urandom_range(0, 1);
            steps = $urandom_range(1, 3);
            for (k = 0; k <= steps; k++)
            begin
                cur = left ? pad - k : pad + k;
                if (cur >= 0 && cur <= 3)
                begin
                    lv = LEVEL_W'(1 << cur);
                    if ($urandom_range(0, 2) == 0)
                        lv = lv | LEVEL_W'(left ? (1 << cur) >> 1 : (1 << cur) << 1);
                    if ($urandom_range(0, 7) == 0)
                        lv = lv | LEVEL_W'($urandom_range(0, 15));
                    hold = $urandom_range(1, span(slide_ms) / (steps + 1) + 2);
                    repeat (hold)
                        queue_tick(lv);
                end
            end
            queue_tick('0);
        end
        else if (kind < 7)
        begin
            queue_tap(span(click_ms) + 2);
        end
        else if (kind == 7)
        begin
            // two taps, the gap ranging around the double-click window
            queue_tap(span(click_ms) + 1);
            repeat ($urandom_range(0, span(clear_ms) + 2 * span(click_ms) + 2))
                queue_tick('0);
            queue_tap(span(click_ms) + 1);
        end
        else if (kind == 8)
        begin
            // long press with changing pads
            hold = $urandom_range(span(click_ms) + 1,
                                  span(click_ms) + span(slide_ms) + 4);
            repeat (hold)
                queue_tick(LEVEL_W'($urandom_range(1, 15)));
            queue_tick('0);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                queue_tick(LEVEL_W'($urandom_range(0, 15)));
        end
    endtask

    // Write one register; valid stays high across back-to-back writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        apply_setting(idx, val);
    endtask

    task automatic load_settings(input int poll,
                                 input int slide,
                                 input int click,
                                 input int clear);
        write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                  CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(CFG_POLL_PERIOD, CFG_DATA_W'(poll));
        write_reg(CFG_SLIDE_LIMIT, CFG_DATA_W'(slide));
        write_reg(CFG_CLICK_LIMIT, CFG_DATA_W'(click));
        write_reg(CFG_CLEAR_DELAY, CFG_DATA_W'(clear));
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    // Wait until no tick is queued, in flight or owed an event word.
    task automatic wait_drained();
        while (pending_levels.size() != 0 || sensor_bus.valid ||
               expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int budget;
        int first;
        int per;
        rst_n                    = 1'b0;
        sensor_bus.valid         = 1'b0;
        sensor_bus.sensor_levels = '0;
        event_bus.ready          = 1'b0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.index            = '0;
        cfg_bus.data             = '0;
        calm                     = 1'b0;
        gap_pct                  = 10;
        stall_pct                = 10;
        reset_gesture_model();

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed ticks run on the reset settings.
        settings_used = 1;
        foreach (directed_ticks[i])
            queue_tick(directed_ticks[i]);
        wait_drained();

        for (phase = 0; phase < PHASES; phase++)
        begin
            budget    = 115;
            gap_pct   = $urandom_range(3, 20);
            stall_pct = $urandom_range(3, 20);
            per       = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000)
                                                    : $urandom_range(1, 200);
            case (phase)
                0:
                begin
                    // stretch with no idling on either side
                    gap_pct   = 0;
                    stall_pct = 0;
                    load_settings(per, per * $urandom_range(0, 10) + $urandom_range(0, per),
                                  per * $urandom_range(0, 6) + $urandom_range(0, per),
                                  per * $urandom_range(0, 5) + $urandom_range(0, per));
                end
                1: load_settings(1, 0, 0, 0);
                // all ones: poll and click limit truncate to their widths
                2: load_settings('1, '1, '1, '1);
                3:
                begin
                    // poll period truncates to zero: the clock stands still
                    budget = 30;
                    load_settings(16'h0400, $urandom_range(0, 500), $urandom_range(0, 300),
                                  $urandom_range(0, 200));
                end
                default:
                begin
                    calm = (phase == PHASES - 1);
                    load_settings(per, per * $urandom_range(0, 10) + $urandom_range(0, per),
                                  per * $urandom_range(0, 6) + $urandom_range(0, per),
                                  per * $urandom_range(0, 5) + $urandom_range(0, per));
                end
            endcase
            first = ticks_queued;
            while (ticks_queued - first < budget)
                queue_gesture();
            wait_drained();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (expected_events.size() != 0)
            failures++;

        $display("Checked %0d event words from %0d poll ticks across %0d register settings.",
                 words_checked, ticks_sent, settings_used);
        $display("Seen %0d presses, %0d slides, %0d clicks, %0d double clicks; %0d failures.",
                 seen_press, seen_slide, seen_click, seen_double, failures);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tsgd_pkg.sv
src/tsgd_if.sv
src/tsgd_cfg_regs.sv
src/tsgd_in_stage.sv
src/tsgd_core.sv
src/tsgd_out_stage.sv
src/touch_strip_gesture_detector.sv
src/tsgd_checker.sv
sim/touch_strip_gesture_detector_tb.sv
